// ===== design/u8d_pkg.sv =====
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = $clog2(QDEPTH);
  localparam int unsigned QCW     = $clog2(QDEPTH + 1);

  // Error kinds as seen on the result channel
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BAD_LEAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_CONT = 2'd2;

  // Byte boundaries of the length table and legality rules
  localparam logic [7:0] B_CONT_LO = 8'h80;
  localparam logic [7:0] B_CONT_HI = 8'hBF;
  localparam logic [7:0] B_LEAD2   = 8'hC0;
  localparam logic [7:0] B_LEAD2_OK = 8'hC2;
  localparam logic [7:0] B_LEAD3   = 8'hE0;
  localparam logic [7:0] B_LEAD_ED = 8'hED;
  localparam logic [7:0] B_LEAD4   = 8'hF0;
  localparam logic [7:0] B_LEAD_MAX = 8'hF4;
  localparam logic [7:0] B_LEAD5   = 8'hF8;
  localparam logic [7:0] B_E0_LO   = 8'hA0;
  localparam logic [7:0] B_ED_HI   = 8'h9F;
  localparam logic [7:0] B_F0_LO   = 8'h90;
  localparam logic [7:0] B_F4_HI   = 8'h8F;

  // What the back end must do with one classified byte
  typedef enum logic [2:0] {
    OP_SINGLE   = 3'd0,
    OP_ERR_LEAD = 3'd1,
    OP_ERR_CONT = 3'd2,
    OP_START    = 3'd3,
    OP_CONT     = 3'd4
  } u8d_op_t;

  typedef struct packed {
    u8d_op_t          op;
    logic [7:0]       data;   // byte, lead payload, or continuation bits
    logic [LEN_W-1:0] len;    // sequence length on a start
    logic             last;   // continuation that closes the sequence
  } u8d_rec_t;

endpackage

// ===== design/u8d_channels.sv =====
`timescale 1ns / 1ps

interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8d_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  seq_length;
  logic        error_flag;
  logic [1:0]  error_kind;
  modport source (output valid, output code_point, output seq_length,
                  output error_flag, output error_kind, input ready);
  modport sink   (input valid, input code_point, input seq_length,
                  input error_flag, input error_kind, output ready);
endinterface

interface u8d_cfg_if;
  logic valid;
  logic ready;
  logic validate_enable;
  modport source (output valid, output validate_enable, input ready);
  modport sink   (input valid, input validate_enable, output ready);
endinterface

// ===== design/u8d_front.sv =====
`timescale 1ns / 1ps

module u8d_front (
  input  logic              clk,
  input  logic              rst,
  u8d_byte_if.sink          stream,
  u8d_cfg_if.sink           cfg,
  input  logic              q_full,
  output logic              push,
  output u8d_pkg::u8d_rec_t push_rec
);
  import u8d_pkg::*;

  logic       validate_enable;
  logic [1:0] rem;
  logic [1:0] rem_next;
  logic [7:0] lead;
  logic [7:0] lead_next;
  logic       second;
  logic       second_next;
  logic [7:0] b;
  logic       ok;
  logic [7:0] lo;
  logic [7:0] hi;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !q_full;
  assign push         = stream.valid && stream.ready;
  assign b            = stream.data_byte;

  // tighter second-byte window after the special leads
  always_comb begin
    lo = B_CONT_LO;
    hi = B_CONT_HI;
    if (lead == B_LEAD3) begin
      lo = B_E0_LO;
    end else if (lead == B_LEAD_ED) begin
      hi = B_ED_HI;
    end else if (lead == B_LEAD4) begin
      lo = B_F0_LO;
    end else if (lead == B_LEAD_MAX) begin
      hi = B_F4_HI;
    end
  end

  always_comb begin
    ok = (b >= B_CONT_LO) && (b <= B_CONT_HI);
    if (second) begin
      ok = ok && (b >= lo) && (b <= hi);
    end
  end

  always_comb begin
    push_rec.op   = OP_SINGLE;
    push_rec.data = b;
    push_rec.len  = LEN_W'(1);
    push_rec.last = 1'b0;
    rem_next      = rem;
    lead_next     = lead;
    second_next   = second;
    if (rem == 2'd0) begin
      if (b < B_LEAD2) begin
        if (validate_enable && (b >= B_CONT_LO)) begin
          push_rec.op = OP_ERR_LEAD;
        end
      end else if ((b >= B_LEAD5) ||
                   (validate_enable && ((b < B_LEAD2_OK) || (b > B_LEAD_MAX)))) begin
        push_rec.op = OP_ERR_LEAD;
      end else begin
        push_rec.op = OP_START;
        lead_next   = b;
        second_next = 1'b1;
        if (b < B_LEAD3) begin
          push_rec.len  = LEN_W'(2);
          push_rec.data = b ^ B_LEAD2;
          rem_next      = 2'd1;
        end else if (b < B_LEAD4) begin
          push_rec.len  = LEN_W'(3);
          push_rec.data = b ^ B_LEAD3;
          rem_next      = 2'd2;
        end else begin
          push_rec.len  = LEN_W'(4);
          push_rec.data = b ^ B_LEAD4;
          rem_next      = 2'd3;
        end
      end
    end else if (validate_enable && !ok) begin
      push_rec.op = OP_ERR_CONT;
      rem_next    = 2'd0;
      lead_next   = 8'd0;
      second_next = 1'b0;
    end else begin
      push_rec.op   = OP_CONT;
      push_rec.data = b ^ B_CONT_LO;
      push_rec.last = (rem == 2'd1);
      rem_next      = rem - 2'd1;
      second_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      validate_enable <= 1'b1;
      rem             <= 2'd0;
      lead            <= 8'd0;
      second          <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        validate_enable <= cfg.validate_enable;
      end
      if (push) begin
        rem    <= rem_next;
        lead   <= lead_next;
        second <= second_next;
      end
    end
  end

endmodule

// ===== design/u8d_queue.sv =====
`timescale 1ns / 1ps

module u8d_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8d_pkg::u8d_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output u8d_pkg::u8d_rec_t head
);
  import u8d_pkg::*;

  u8d_rec_t         mem [QDEPTH];
  logic [QAW-1:0]   wptr;
  logic [QAW-1:0]   rptr;
  logic [QCW-1:0]   count;

  assign full  = (count == QCW'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

// ===== design/u8d_back.sv =====
`timescale 1ns / 1ps

module u8d_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  u8d_pkg::u8d_rec_t head,
  output logic              pop,
  u8d_result_if.source      decoded
);
  import u8d_pkg::*;

  logic [CP_W-1:0]  partial;
  logic [LEN_W-1:0] total;
  logic [CP_W-1:0]  shifted;
  logic             emit;
  logic [CP_W-1:0]  cp_next;
  logic [LEN_W-1:0] len_next;
  logic [KIND_W-1:0] kind_next;

  // output register may take a new result when empty or being drained
  assign pop     = !empty && (!decoded.valid || decoded.ready);
  assign shifted = {partial[CP_W-7:0], 6'b0} | {{(CP_W-8){1'b0}}, head.data};

  always_comb begin
    emit      = 1'b0;
    cp_next   = '0;
    len_next  = '0;
    kind_next = KIND_NONE;
    case (head.op)
      OP_SINGLE: begin
        emit     = 1'b1;
        cp_next  = {{(CP_W-8){1'b0}}, head.data};
        len_next = LEN_W'(1);
      end
      OP_ERR_LEAD: begin
        emit      = 1'b1;
        kind_next = KIND_BAD_LEAD;
      end
      OP_ERR_CONT: begin
        emit      = 1'b1;
        kind_next = KIND_BAD_CONT;
      end
      OP_CONT: begin
        emit     = head.last;
        cp_next  = shifted;
        len_next = total;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head.op)
        OP_START: begin
          partial <= {{(CP_W-8){1'b0}}, head.data};
          total   <= head.len;
        end
        OP_CONT: begin
          partial <= shifted;
        end
        default: begin
          partial <= '0;
          total   <= '0;
        end
      endcase
    end
    if (pop && emit) begin
      decoded.code_point <= cp_next;
      decoded.seq_length <= len_next;
      decoded.error_flag <= (kind_next != KIND_NONE);
      decoded.error_kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decoded.valid <= 1'b0;
    end else if (pop) begin
      decoded.valid <= emit;
    end else if (decoded.ready) begin
      decoded.valid <= 1'b0;
    end
  end

endmodule

// ===== design/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps

// UTF-8 stream decoder with optional legality checking.
//
// stream  : one raw byte per beat (data_byte). Accepted when valid && ready.
// cfg     : write beat carrying validate_enable (reset 1). Write it only
//           while no sequence is in flight and the result channel is drained.
// decoded : at most one result per input byte: code_point, seq_length,
//           error_flag, error_kind. A multi-byte sequence yields one result
//           on its final byte; leading bytes yield none.
//
// Throughput is one byte per cycle while the queue is not full. An accepted
// byte goes through the classification queue and then the output register before
// its result beat. The front end checks each byte against the sequence
// state and pushes a classified record into a four-entry queue; the back end
// assembles the code point and loads the output register.
// When the receiver stalls, the output register holds, the queue fills and
// stream.ready drops once four records wait. Reset empties the queue, clears
// the output valid, returns the decoder to idle and sets validate_enable.
module utf8_stream_decoder (
  input  logic          clk,
  input  logic          rst,
  u8d_byte_if.sink      stream,
  u8d_cfg_if.sink       cfg,
  u8d_result_if.source  decoded
);
  import u8d_pkg::*;

  logic     q_full;
  logic     q_empty;
  logic     push;
  logic     pop;
  u8d_rec_t push_rec;
  u8d_rec_t head;

  // classify each byte and track where we are in the sequence
  u8d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .stream   (stream),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  // decouple the byte side from the result side
  u8d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  // assemble code points and drive the result register
  u8d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (q_empty),
    .head    (head),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

// ===== verif/utf8_stream_decoder_tb.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
  import u8d_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 9;
  // The output register plus a four-deep queue; a lead byte leaves no result
  // behind, so give the block this many quiet cycles before touching the register.
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_BYTES    = 155;
  localparam int NUM_PHASES     = 6;
  localparam int IDLE_PCT       = 11;
  localparam int MAX_REPORTS    = 10;
  // validate_enable per random phase, phase 0 in bit 0
  localparam logic [NUM_PHASES-1:0] PHASE_VALIDATE = 6'b100101;

  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic [LEN_W-1:0]  len;
    logic              flag;
    logic [KIND_W-1:0] kind;
  } cp_result_t;

  // Directed rows: feed a byte and predict, feed a byte against a typed
  // result, or rewrite validate_enable (value in bit 0 of data).
  typedef enum logic [1:0] {
    ROW_FEED,
    ROW_FEED_TYPED,
    ROW_SET_VALIDATE
  } row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [7:0]        data;
    logic [CP_W-1:0]   cp;
    logic [LEN_W-1:0]  len;
    logic [KIND_W-1:0] kind;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(CLK_HALF) clk = ~clk;

  u8d_byte_if   stream_ch ();
  u8d_cfg_if    cfg_ch ();
  u8d_result_if dec_ch ();

  utf8_stream_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .cfg     (cfg_ch),
    .decoded (dec_ch)
  );

  // Decoder state as the testbench tracks it
  logic              pr_validate  = 1'b1;
  logic [1:0]        pr_remaining = '0;
  logic [CP_W-1:0]   pr_partial   = '0;
  logic [7:0]        pr_lead      = '0;
  logic              pr_second    = 1'b0;
  logic [LEN_W-1:0]  pr_total     = '0;

  cp_result_t expected_cps [$];
  dir_row_t   dir_tab [27];

  int   mismatches   = 0;
  int   bytes_sent   = 0;
  int   quiet_cycles = 0;
  bit   sender_gaps  = 1'b1;
  logic sink_gaps    = 1'b1;
  logic hold_req     = 1'b0;
  logic hold_taken   = 1'b0;
  int   hold_left    = 0;

  // Legal window of the second byte after a given lead byte.
  function automatic void second_window(input logic [7:0] lead,
                                        output logic [7:0] lo, output logic [7:0] hi);
    lo = B_CONT_LO;
    hi = B_CONT_HI;
    case (lead)
      B_LEAD3:    lo = B_E0_LO;
      B_LEAD_ED:  hi = B_ED_HI;
      B_LEAD4:    lo = B_F0_LO;
      B_LEAD_MAX: hi = B_F4_HI;
      default: ;
    endcase
  endfunction

  function automatic void seq_reset();
    pr_remaining = '0;
    pr_partial   = '0;
    pr_lead      = '0;
    pr_second    = 1'b0;
    pr_total     = '0;
  endfunction

  // Advance the tracked state by one byte; return 1 when the byte closes a
  // sequence or is rejected, with the code point result in r.
  function automatic bit decode_byte(input logic [7:0] b, output cp_result_t r);
    logic             chk;
    logic             ok;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic [LEN_W-1:0] len;
    logic [7:0]       payload;
    chk = pr_validate;
    r   = '0;
    if (pr_remaining == 0) begin
      // Below 0xC0 is a single byte, unless it is a stray continuation
      // under validation.
      if (b < B_LEAD2) begin
        seq_reset();
        if (chk && b >= B_CONT_LO) begin
          r.flag = 1'b1;
          r.kind = KIND_BAD_LEAD;
        end else begin
          r.cp  = CP_W'(b);
          r.len = 3'd1;
        end
        return 1'b1;
      end
      // Five- and six-byte leads are always rejected; overlong and
      // out-of-range leads only under validation.
      if (b >= B_LEAD5 || (chk && (b < B_LEAD2_OK || b > B_LEAD_MAX))) begin
        seq_reset();
        r.flag = 1'b1;
        r.kind = KIND_BAD_LEAD;
        return 1'b1;
      end
      if (b < B_LEAD3) begin
        len     = 3'd2;
        payload = b ^ B_LEAD2;
      end else if (b < B_LEAD4) begin
        len     = 3'd3;
        payload = b ^ B_LEAD3;
      end else begin
        len     = 3'd4;
        payload = b ^ B_LEAD4;
      end
      pr_remaining = 2'(len - 3'd1);
      pr_partial   = CP_W'(payload);
      pr_lead      = b;
      pr_second    = 1'b1;
      pr_total     = len;
      return 1'b0;
    end

    if (chk) begin
      ok = (b >= B_CONT_LO && b <= B_CONT_HI);
      if (ok && pr_second) begin
        second_window(pr_lead, lo, hi);
        ok = (b >= lo && b <= hi);
      end
      if (!ok) begin
        seq_reset();
        r.flag = 1'b1;
        r.kind = KIND_BAD_CONT;
        return 1'b1;
      end
    end

    // Unchecked bytes keep all eight bits after the XOR; the shift
    // drops whatever falls off the top of 21 bits.
    pr_partial   = (pr_partial << 6) | CP_W'(b ^ B_CONT_LO);
    pr_second    = 1'b0;
    pr_remaining = pr_remaining - 2'd1;
    if (pr_remaining == 0) begin
      r.cp  = pr_partial;
      r.len = pr_total;
      seq_reset();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one byte, maybe after a one-cycle gap, and hold it until the beat
  // is taken. Record what the block should answer with.
  task automatic push_byte(input logic [7:0] b, input bit typed, input cp_result_t typed_r);
    cp_result_t r;
    bit         has;
    if (sender_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      stream_ch.valid <= 1'b0;
      @(posedge clk);
    end
    stream_ch.valid     <= 1'b1;
    stream_ch.data_byte <= b;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    has = decode_byte(b, r);
    if (typed)
      expected_cps.push_back(typed_r);
    else if (has)
      expected_cps.push_back(r);
    bytes_sent++;
  endtask

  // Drop valid and wait until every predicted result has come out, then
  // let any trailing lead-byte record clear the pipeline.
  task automatic drain_results();
    stream_ch.valid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_validate(input logic v);
    cfg_ch.validate_enable <= v;
    cfg_ch.valid           <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    pr_validate = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // Finish or break any open sequence so the block is idle at a phase end.
  task automatic close_sequence();
    while (pr_remaining != 0) push_byte(B_E0_LO, 1'b0, '0);
  endtask

  // One random chunk: mostly a well-formed sequence with random content,
  // some truncated by a random byte, the rest single noise bytes.
  task automatic push_chunk();
    logic [7:0] seq [4];
    logic [7:0] lo;
    logic [7:0] hi;
    int         n;
    int         cut;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick >= 85) begin
      push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      n = $urandom_range(1, 4);
      case (n)
        1: seq[0] = 8'($urandom_range(0, 127));
        2: seq[0] = 8'($urandom_range(B_LEAD2_OK, 8'hDF));
        3: begin
          // lean on the leads with a narrowed second-byte window
          if ($urandom_range(0, 3) == 0)
            seq[0] = $urandom_range(0, 1) ? B_LEAD3 : B_LEAD_ED;
          else
            seq[0] = 8'($urandom_range(B_LEAD3, 8'hEF));
        end
        default: begin
          if ($urandom_range(0, 3) == 0)
            seq[0] = $urandom_range(0, 1) ? B_LEAD4 : B_LEAD_MAX;
          else
            seq[0] = 8'($urandom_range(B_LEAD4, B_LEAD_MAX));
        end
      endcase
      second_window(seq[0], lo, hi);
      for (int i = 1; i < n; i++)
        seq[i] = (i == 1) ? 8'($urandom_range(lo, hi))
                          : 8'($urandom_range(B_CONT_LO, B_CONT_HI));
      cut = n;
      if (pick >= 70 && n > 1) begin
        cut = $urandom_range(2, n);
        seq[cut-1] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < cut; i++) push_byte(seq[i], 1'b0, '0);
    end
  endtask

  // Result sink: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      dec_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      dec_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_taken   <= 1'b1;
    end else begin
      dec_ch.ready <= !sink_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each result beat against the oldest prediction.
  always @(posedge clk) begin
    cp_result_t got;
    cp_result_t want;
    if (!rst && dec_ch.valid && dec_ch.ready) begin
      got = '{dec_ch.code_point, dec_ch.seq_length, dec_ch.error_flag, dec_ch.error_kind};
      if (expected_cps.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result beat: cp=%h len=%0d err=%0b kind=%0d",
                   got.cp, got.len, got.flag, got.kind);
        mismatches++;
      end else begin
        want = expected_cps.pop_front();
        if (got.cp !== want.cp || got.len !== want.len ||
            got.flag !== want.flag || got.kind !== want.kind) begin
          if (mismatches < MAX_REPORTS)
            $display({"mismatch: expected cp=%h len=%0d err=%0b kind=%0d,",
                      " got cp=%h len=%0d err=%0b kind=%0d"},
                     want.cp, want.len, want.flag, want.kind,
                     got.cp, got.len, got.flag, got.kind);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((stream_ch.valid && stream_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (dec_ch.valid && dec_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t   row;
    cp_result_t typed_r;
    bit         paused;
    paused = 1'b0;

    stream_ch.valid        <= 1'b0;
    stream_ch.data_byte    <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.validate_enable <= 1'b1;

    // Directed pass: reset value of validate_enable first, then off.
    dir_tab = '{
      '{ROW_FEED_TYPED,   8'h00, 21'h0,     3'd1, KIND_NONE},      // lowest ASCII
      '{ROW_FEED_TYPED,   8'h7F, 21'h7F,    3'd1, KIND_NONE},      // highest ASCII
      '{ROW_FEED_TYPED,   8'h80, 21'h0,     3'd0, KIND_BAD_LEAD},  // stray continuation
      '{ROW_FEED_TYPED,   8'hC1, 21'h0,     3'd0, KIND_BAD_LEAD},  // overlong lead
      '{ROW_FEED_TYPED,   8'hF5, 21'h0,     3'd0, KIND_BAD_LEAD},  // beyond U+10FFFF
      '{ROW_FEED_TYPED,   8'hFF, 21'h0,     3'd0, KIND_BAD_LEAD},
      '{ROW_FEED,         8'hE0, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED_TYPED,   8'h9F, 21'h0,     3'd0, KIND_BAD_CONT},  // E0 overlong
      '{ROW_FEED,         8'hED, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED_TYPED,   8'hA0, 21'h0,     3'd0, KIND_BAD_CONT},  // surrogate
      '{ROW_FEED,         8'hF0, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED_TYPED,   8'h8F, 21'h0,     3'd0, KIND_BAD_CONT},  // F0 overlong
      '{ROW_FEED,         8'hF4, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED_TYPED,   8'h90, 21'h0,     3'd0, KIND_BAD_CONT},  // above U+10FFFF
      '{ROW_FEED,         8'hF4, 21'h0,     3'd0, KIND_NONE},      // top scalar value
      '{ROW_FEED,         8'h8F, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED,         8'hBF, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED,         8'hBF, 21'h0,     3'd0, KIND_NONE},
      '{ROW_SET_VALIDATE, 8'h00, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED_TYPED,   8'h80, 21'h80,    3'd1, KIND_NONE},      // stray byte passes
      '{ROW_FEED_TYPED,   8'hF8, 21'h0,     3'd0, KIND_BAD_LEAD},  // five-byte lead
      '{ROW_FEED,         8'hC0, 21'h0,     3'd0, KIND_NONE},      // unchecked overlong
      '{ROW_FEED,         8'h00, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED,         8'hF7, 21'h0,     3'd0, KIND_NONE},      // unchecked junk
      '{ROW_FEED,         8'hFF, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED,         8'hFF, 21'h0,     3'd0, KIND_NONE},
      '{ROW_FEED,         8'hFF, 21'h0,     3'd0, KIND_NONE}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      row = dir_tab[k];
      if (row.op == ROW_SET_VALIDATE) begin
        drain_results();
        write_validate(row.data[0]);
      end else begin
        typed_r = '{row.cp, row.len, row.kind != KIND_NONE, row.kind};
        push_byte(row.data, row.op == ROW_FEED_TYPED, typed_r);
      end
    end

    // Random phases. Phase 0 carries the long result hold-off, phase 2 runs
    // with no idling on either side, phase 3 pauses the sender mid-stream.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_validate(PHASE_VALIDATE[ph]);
      sender_gaps = (ph != 2);
      sink_gaps  <= (ph != 2);
      bytes_sent  = 0;
      while (bytes_sent < PHASE_BYTES) begin
        if (ph == 0 && bytes_sent >= 20)
          hold_req <= 1'b1;
        if (ph == 3 && bytes_sent >= 80 && !paused) begin
          paused = 1'b1;
          drain_results();
        end
        push_chunk();
      end
      close_sequence();
    end

    drain_results();
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== utf8_stream_decoder.f =====
design/u8d_pkg.sv
design/u8d_channels.sv
design/u8d_front.sv
design/u8d_queue.sv
design/u8d_back.sv
design/utf8_stream_decoder.sv
verif/utf8_stream_decoder_tb.sv
